### hw/rtl/olnc_pkg.sv
package olnc_pkg;

    localparam int TIME_W   = 32;
    localparam int DIST_W   = 12;
    localparam int SPEED_W  = 8;
    localparam int CMD_W    = 3;
    localparam int NAVC_W   = 3;
    localparam int KIND_W   = 3;
    localparam int SOUND_W  = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;

    localparam logic [TIME_W-1:0] UPDATE_PERIOD_MS = TIME_W'(100);
    localparam logic [TIME_W-1:0] SAFETY_PERIOD_MS = TIME_W'(500);
    localparam logic [DIST_W-1:0] OBSTACLE_MM      = DIST_W'(200);
    localparam logic [DIST_W-1:0] CLOSE_MM         = DIST_W'(150);

    localparam logic [SPEED_W-1:0] RST_BASE_SPEED    = SPEED_W'(150);
    localparam logic [SPEED_W-1:0] RST_TURN_SPEED    = SPEED_W'(120);
    localparam logic [SPEED_W-1:0] RST_AVOID_SPEED   = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] RST_REVERSE_SPEED = SPEED_W'(100);
    localparam logic [TIME_W-1:0]  RST_STATE_TIMEOUT = TIME_W'(3000);
    localparam logic [TIME_W-1:0]  RST_MAX_OBSTACLE  = TIME_W'(10000);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_RESET  = 3'd5
    } t_cmd;

    // one-hot navigation state
    typedef enum logic [6:0] {
        NAV_FWD   = 7'b0000001,
        NAV_TL    = 7'b0000010,
        NAV_TR    = 7'b0000100,
        NAV_BACK  = 7'b0001000,
        NAV_PARK  = 7'b0010000,
        NAV_AL    = 7'b0100000,
        NAV_AR    = 7'b1000000
    } t_nav;

    typedef enum logic [NAVC_W-1:0] {
        NAVC_FWD  = 3'd0,
        NAVC_TL   = 3'd1,
        NAVC_TR   = 3'd2,
        NAVC_BACK = 3'd3,
        NAVC_STOP = 3'd4,
        NAVC_AL   = 3'd5,
        NAVC_AR   = 3'd6
    } t_nav_code;

    typedef enum logic [KIND_W-1:0] {
        DRV_FWD   = 3'd0,
        DRV_LEFT  = 3'd1,
        DRV_RIGHT = 3'd2,
        DRV_BACK  = 3'd3,
        DRV_STOP  = 3'd4
    } t_drive;

    typedef enum logic [SOUND_W-1:0] {
        SND_NONE  = 2'd0,
        SND_START = 2'd1,
        SND_OFF   = 2'd2,
        SND_SIREN = 2'd3
    } t_sound;

    typedef enum logic [2:0] {
        REG_BASE_SPEED    = 3'd0,
        REG_TURN_SPEED    = 3'd1,
        REG_AVOID_SPEED   = 3'd2,
        REG_REVERSE_SPEED = 3'd3,
        REG_STATE_TIMEOUT = 3'd4,
        REG_MAX_OBSTACLE  = 3'd5,
        REG_LINE_FOLLOW   = 3'd6,
        REG_SAFETY        = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0] base_speed;
        logic [SPEED_W-1:0] turn_speed;
        logic [SPEED_W-1:0] avoid_speed;
        logic [SPEED_W-1:0] reverse_speed;
        logic [TIME_W-1:0]  state_timeout_ms;
        logic [TIME_W-1:0]  max_obstacle_ms;
        logic               line_follow_enable;
        logic               safety_enable;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] time_ms;
        logic              ir_left;
        logic              ir_center;
        logic              ir_right;
        logic [DIST_W-1:0] distance_mm;
    } t_item;

    typedef struct packed {
        logic [NAVC_W-1:0]  nav_state;
        logic               drive_valid;
        logic [KIND_W-1:0]  drive_kind;
        logic [SPEED_W-1:0] drive_speed;
        logic [SOUND_W-1:0] sound_code;
        logic               active_flag;
        logic               paused_flag;
        logic               obstacle_flag;
    } t_result;

    function automatic logic [NAVC_W-1:0] nav_code(input t_nav nav);
        logic [NAVC_W-1:0] code;
        unique case (nav)
            NAV_FWD:  code = NAVC_FWD;
            NAV_TL:   code = NAVC_TL;
            NAV_TR:   code = NAVC_TR;
            NAV_BACK: code = NAVC_BACK;
            NAV_AL:   code = NAVC_AL;
            NAV_AR:   code = NAVC_AR;
            default:  code = NAVC_STOP;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/olnc_if.sv
interface olnc_in_if import olnc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] time_ms;
    logic              ir_left;
    logic              ir_center;
    logic              ir_right;
    logic [DIST_W-1:0] distance_mm;

    modport source (
        output valid, cmd, time_ms, ir_left, ir_center, ir_right, distance_mm,
        input  ready
    );
    modport sink (
        input  valid, cmd, time_ms, ir_left, ir_center, ir_right, distance_mm,
        output ready
    );
endinterface

interface olnc_out_if import olnc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NAVC_W-1:0]  nav_state;
    logic               drive_valid;
    logic [KIND_W-1:0]  drive_kind;
    logic [SPEED_W-1:0] drive_speed;
    logic [SOUND_W-1:0] sound_code;
    logic               active_flag;
    logic               paused_flag;
    logic               obstacle_flag;

    modport source (
        output valid, nav_state, drive_valid, drive_kind, drive_speed, sound_code,
               active_flag, paused_flag, obstacle_flag,
        input  ready
    );
    modport sink (
        input  valid, nav_state, drive_valid, drive_kind, drive_speed, sound_code,
               active_flag, paused_flag, obstacle_flag,
        output ready
    );
endinterface

### hw/rtl/olnc_cfg.sv
module olnc_cfg import olnc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed         <= RST_BASE_SPEED;
            r_cfg.turn_speed         <= RST_TURN_SPEED;
            r_cfg.avoid_speed        <= RST_AVOID_SPEED;
            r_cfg.reverse_speed      <= RST_REVERSE_SPEED;
            r_cfg.state_timeout_ms   <= RST_STATE_TIMEOUT;
            r_cfg.max_obstacle_ms    <= RST_MAX_OBSTACLE;
            r_cfg.line_follow_enable <= 1'b1;
            r_cfg.safety_enable      <= 1'b1;
        end else if (wr_en) begin
            unique case (idx)
                REG_BASE_SPEED:    r_cfg.base_speed         <= pwdata[SPEED_W-1:0];
                REG_TURN_SPEED:    r_cfg.turn_speed         <= pwdata[SPEED_W-1:0];
                REG_AVOID_SPEED:   r_cfg.avoid_speed        <= pwdata[SPEED_W-1:0];
                REG_REVERSE_SPEED: r_cfg.reverse_speed      <= pwdata[SPEED_W-1:0];
                REG_STATE_TIMEOUT: r_cfg.state_timeout_ms   <= pwdata[TIME_W-1:0];
                REG_MAX_OBSTACLE:  r_cfg.max_obstacle_ms    <= pwdata[TIME_W-1:0];
                REG_LINE_FOLLOW:   r_cfg.line_follow_enable <= pwdata[0];
                REG_SAFETY:        r_cfg.safety_enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BASE_SPEED:    prdata = APB_DW'(r_cfg.base_speed);
            REG_TURN_SPEED:    prdata = APB_DW'(r_cfg.turn_speed);
            REG_AVOID_SPEED:   prdata = APB_DW'(r_cfg.avoid_speed);
            REG_REVERSE_SPEED: prdata = APB_DW'(r_cfg.reverse_speed);
            REG_STATE_TIMEOUT: prdata = APB_DW'(r_cfg.state_timeout_ms);
            REG_MAX_OBSTACLE:  prdata = APB_DW'(r_cfg.max_obstacle_ms);
            REG_LINE_FOLLOW:   prdata = APB_DW'(r_cfg.line_follow_enable);
            REG_SAFETY:        prdata = APB_DW'(r_cfg.safety_enable);
            default:           prdata = '0;
        endcase
    end

endmodule

### hw/rtl/olnc_core.sv
module olnc_core import olnc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic              r_running, n_running;
    logic              r_halted, n_halted;
    t_nav              r_nav, n_nav;
    logic [TIME_W-1:0] r_last_tick, n_last_tick;
    logic [TIME_W-1:0] r_entry, n_entry;
    logic              r_obs_seen, n_obs_seen;
    logic [TIME_W-1:0] r_since, n_since;
    logic [TIME_W-1:0] r_last_safety, n_last_safety;
    logic              r_line_left, n_line_left;

    logic [TIME_W-1:0] now;
    logic              l, c, r;
    logic              tick_ok, obs, safe_chk, fire;
    logic [TIME_W-1:0] since_nx;
    t_nav              nav1, nav2, target;
    logic              has_target, changed, timeout;
    logic              line_left_nx;
    logic [SPEED_W-1:0] t_speed;
    logic [KIND_W-1:0]  t_kind;

    assign now = i_item.time_ms;
    assign l   = i_item.ir_left;
    assign c   = i_item.ir_center;
    assign r   = i_item.ir_right;

    // tick datapath
    always_comb begin
        tick_ok  = r_running && !r_halted && ((now - r_last_tick) >= UPDATE_PERIOD_MS);
        obs      = l || c || r || (i_item.distance_mm < OBSTACLE_MM);
        since_nx = !obs ? '0 : ((r_since == '0) ? now : r_since);
        safe_chk = i_cfg.safety_enable && ((now - r_last_safety) >= SAFETY_PERIOD_MS);
        // a freshly recorded obstacle start gives a zero span, so only r_since matters
        fire     = safe_chk && obs && (r_since != '0) &&
                   ((now - r_since) > i_cfg.max_obstacle_ms);
        nav1     = fire ? NAV_PARK : r_nav;

        has_target   = 1'b0;
        target       = NAV_FWD;
        line_left_nx = r_line_left;
        if (obs) begin
            if (c) begin
                has_target = 1'b1;
                if (i_item.distance_mm < CLOSE_MM) target = NAV_BACK;
                else if (!l && r)                  target = NAV_AL;
                else if (l && !r)                  target = NAV_AR;
                else                               target = NAV_BACK;
            end else if (l) begin
                has_target = 1'b1;
                target     = NAV_AR;
            end else if (r) begin
                has_target = 1'b1;
                target     = NAV_AL;
            end
        end else if (i_cfg.line_follow_enable) begin
            has_target = 1'b1;
            if (l && c && r) begin
                target = NAV_FWD;  line_left_nx = 1'b0;
            end else if (l && c) begin
                target = NAV_TL;   line_left_nx = 1'b1;
            end else if (c && r) begin
                target = NAV_TR;   line_left_nx = 1'b0;
            end else if (l) begin
                target = NAV_TL;   line_left_nx = 1'b1;
            end else if (r) begin
                target = NAV_TR;   line_left_nx = 1'b0;
            end else begin
                target = r_line_left ? NAV_TL : NAV_TR;
            end
        end

        nav2    = has_target ? target : nav1;
        changed = (fire && (r_nav != NAV_PARK)) || (has_target && (target != nav1));
        // after an entry-time update the span is zero, so the timeout cannot fire
        timeout = !changed && ((now - r_entry) > i_cfg.state_timeout_ms) &&
                  ((nav2 == NAV_BACK) || (nav2 == NAV_AL) || (nav2 == NAV_AR));

        unique case (nav2)
            NAV_FWD:  begin t_kind = DRV_FWD;   t_speed = i_cfg.base_speed;    end
            NAV_TL:   begin t_kind = DRV_LEFT;  t_speed = i_cfg.turn_speed;    end
            NAV_TR:   begin t_kind = DRV_RIGHT; t_speed = i_cfg.turn_speed;    end
            NAV_BACK: begin t_kind = DRV_BACK;  t_speed = i_cfg.reverse_speed; end
            NAV_AL:   begin t_kind = DRV_LEFT;  t_speed = i_cfg.avoid_speed;   end
            NAV_AR:   begin t_kind = DRV_RIGHT; t_speed = i_cfg.avoid_speed;   end
            default:  begin t_kind = DRV_STOP;  t_speed = '0;                  end
        endcase
    end

    // command decode
    always_comb begin
        n_running     = r_running;
        n_halted      = r_halted;
        n_nav         = r_nav;
        n_last_tick   = r_last_tick;
        n_entry       = r_entry;
        n_obs_seen    = r_obs_seen;
        n_since       = r_since;
        n_last_safety = r_last_safety;
        n_line_left   = r_line_left;
        o_res         = '0;

        unique case (t_cmd'(i_item.cmd))
            CMD_TICK: begin
                if (tick_ok) begin
                    n_obs_seen        = obs;
                    n_since           = since_nx;
                    n_line_left       = line_left_nx;
                    n_last_tick       = now;
                    n_nav             = timeout ? NAV_FWD : nav2;
                    n_entry           = (changed || timeout) ? now : r_entry;
                    if (safe_chk) n_last_safety = now;
                    o_res.drive_valid = 1'b1;
                    o_res.drive_kind  = t_kind;
                    o_res.drive_speed = t_speed;
                    if (fire) o_res.sound_code = SND_SIREN;
                end
            end
            CMD_START: begin
                if (!r_running) begin
                    n_running        = 1'b1;
                    n_halted         = 1'b0;
                    n_nav            = NAV_FWD;
                    n_entry          = now;
                    n_last_tick      = now;
                    o_res.sound_code = SND_START;
                end
            end
            CMD_STOP, CMD_RESET: begin
                if (r_running) begin
                    n_running         = 1'b0;
                    n_halted          = 1'b0;
                    n_nav             = NAV_PARK;
                    o_res.drive_valid = 1'b1;
                    o_res.drive_kind  = DRV_STOP;
                    o_res.sound_code  = SND_OFF;
                end
                if (t_cmd'(i_item.cmd) == CMD_RESET) begin
                    n_nav       = NAV_FWD;
                    n_entry     = '0;
                    n_obs_seen  = 1'b0;
                    n_line_left = 1'b0;
                end
            end
            CMD_PAUSE: begin
                if (r_running && !r_halted) begin
                    n_halted          = 1'b1;
                    n_nav             = NAV_PARK;
                    o_res.drive_valid = 1'b1;
                    o_res.drive_kind  = DRV_STOP;
                end
            end
            CMD_RESUME: begin
                if (r_running && r_halted) begin
                    n_halted = 1'b0;
                    n_nav    = NAV_FWD;
                    n_entry  = now;
                end
            end
            default: ;
        endcase

        o_res.nav_state     = nav_code(n_nav);
        o_res.active_flag   = n_running;
        o_res.paused_flag   = n_halted;
        o_res.obstacle_flag = n_obs_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_halted      <= 1'b0;
            r_nav         <= NAV_FWD;
            r_last_tick   <= '0;
            r_entry       <= '0;
            r_obs_seen    <= 1'b0;
            r_since       <= '0;
            r_last_safety <= '0;
            r_line_left   <= 1'b0;
        end else if (i_adv) begin
            r_running     <= n_running;
            r_halted      <= n_halted;
            r_nav         <= n_nav;
            r_last_tick   <= n_last_tick;
            r_entry       <= n_entry;
            r_obs_seen    <= n_obs_seen;
            r_since       <= n_since;
            r_last_safety <= n_last_safety;
            r_line_left   <= n_line_left;
        end
    end

endmodule

### hw/rtl/obstacle_line_nav_controller_top.sv
// Rover navigation controller.
// Input channel i_in carries commands (tick, start, stop, pause, resume,
// reset) with a millisecond timestamp, three IR flags and a distance.
// Output channel o_out returns exactly one result per command: nav state,
// motor command with speed, sound code and the active/paused/obstacle flags.
// Both channels transfer on valid && ready at the rising clock edge.
// A command lands in the input register r_item when it transfers, and the
// result register r_res loads from it once the output is free or taken.
// Throughput: one command per cycle while the receiver does not stall; the
// whole decision is combinational between the input and result registers,
// and the nav state registers update with r_res, so the next command sees them.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; after that ready drops until the result moves.
// Configuration registers sit on the APB port at byte address 4*index and
// are meant to be written while the block is idle.
// Synchronous reset i_rst_n clears the channels, the nav state (forward,
// not running) and loads the default speeds and time limits.
module obstacle_line_nav_controller_top import olnc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    olnc_in_if.sink           i_in,
    olnc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_result res;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    logic    adv;

    olnc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    olnc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.cmd         <= i_in.cmd;
            r_item.time_ms     <= i_in.time_ms;
            r_item.ir_left     <= i_in.ir_left;
            r_item.ir_center   <= i_in.ir_center;
            r_item.ir_right    <= i_in.ir_right;
            r_item.distance_mm <= i_in.distance_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.nav_state     = r_res.nav_state;
    assign o_out.drive_valid   = r_res.drive_valid;
    assign o_out.drive_kind    = r_res.drive_kind;
    assign o_out.drive_speed   = r_res.drive_speed;
    assign o_out.sound_code    = r_res.sound_code;
    assign o_out.active_flag   = r_res.active_flag;
    assign o_out.paused_flag   = r_res.paused_flag;
    assign o_out.obstacle_flag = r_res.obstacle_flag;

endmodule

### hw/rtl/olnc_checker.sv
module olnc_checker import olnc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [NAVC_W-1:0]  i_nav_state,
    input logic               i_drive_valid,
    input logic [KIND_W-1:0]  i_drive_kind,
    input logic [SPEED_W-1:0] i_drive_speed,
    input logic [SOUND_W-1:0] i_sound_code,
    input logic               i_active,
    input logic               i_paused
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_nav_state) &&
        $stable(i_drive_kind) && $stable(i_sound_code)))
        else $error("result changed while stalled");

    // no motor command means empty drive fields
    a_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_drive_valid) |-> (i_drive_kind == DRV_FWD && i_drive_speed == '0))
        else $error("drive fields set without motor command");

    // paused only exists while running
    a_pause_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_paused) |-> i_active)
        else $error("paused while not active");

    // power off always comes with a stop drive; a reset command may leave forward state
    a_power_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sound_code == SND_OFF) |->
        (!i_active && i_drive_valid && i_drive_kind == DRV_STOP && i_drive_speed == '0))
        else $error("power off without stop");

    // the siren only sounds on a handled tick, which always drives
    a_siren: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sound_code == SND_SIREN) |-> (i_drive_valid && i_active && !i_paused))
        else $error("siren without handled tick");

endmodule

bind obstacle_line_nav_controller_top olnc_checker u_olnc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_nav_state   (o_out.nav_state),
    .i_drive_valid (o_out.drive_valid),
    .i_drive_kind  (o_out.drive_kind),
    .i_drive_speed (o_out.drive_speed),
    .i_sound_code  (o_out.sound_code),
    .i_active      (o_out.active_flag),
    .i_paused      (o_out.paused_flag)
);
